// ===== hw/rtl/jtps_pkg.sv =====
// Shared types and constants for the joystick to PS/2 scancode block.
// Holds the key codes, byte phases, queue entry and configuration types.
// No dependencies.
`default_nettype none

package jtps_pkg;

	localparam int NumKeys = 6;
	localparam int KeyIdxW = 3;
	localparam int QueueDepth = 2;

	localparam logic [7:0] Centre = 8'd127;
	localparam logic [7:0] PrefixEsc = 8'hE0;
	localparam logic [7:0] PrefixBreak = 8'hF0;
	localparam logic [6:0] DeadZoneReset = 7'd50;

	// Key positions in the flag vector.
	localparam logic [KeyIdxW-1:0] KeyUp = 3'd0;
	localparam logic [KeyIdxW-1:0] KeyDown = 3'd1;
	localparam logic [KeyIdxW-1:0] KeyLeft = 3'd2;
	localparam logic [KeyIdxW-1:0] KeyRight = 3'd3;
	localparam logic [KeyIdxW-1:0] KeyCtrl = 3'd4;
	localparam logic [KeyIdxW-1:0] KeySpace = 3'd5;

	// Register indexes on the configuration port.
	localparam logic RegOutputEnable = 1'b0;
	localparam logic RegDeadZone = 1'b1;

	// Byte phases within one key sequence.
	localparam logic [1:0] PhEsc = 2'd0;
	localparam logic [1:0] PhBreak = 2'd1;
	localparam logic [1:0] PhCode = 2'd2;

	typedef struct packed {
		logic       output_enable;
		logic [6:0] dead_zone;
	} cfg_t;

	// One report waiting for the byte generator.
	typedef struct packed {
		logic [NumKeys-1:0] changed;
		logic [NumKeys-1:0] now;
	} entry_t;

	function automatic logic [7:0] key_code(input logic [KeyIdxW-1:0] k);
		logic [7:0] c;
		case (k)
			KeyUp: c = 8'h75;
			KeyDown: c = 8'h72;
			KeyLeft: c = 8'h6B;
			KeyRight: c = 8'h74;
			KeyCtrl: c = 8'h14;
			KeySpace: c = 8'h29;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Arrow keys are the extended ones that need the E0 prefix.
	function automatic logic key_escaped(input logic [KeyIdxW-1:0] k);
		return (k == KeyUp) || (k == KeyDown) || (k == KeyLeft) || (k == KeyRight);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jtps_front.sv =====
// Front end: accepts reports, derives the key flags and keeps the flag state.
// Pushes the changed-key mask into the queue. Depends on jtps_pkg.
`default_nettype none

module jtps_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire jtps_pkg::cfg_t      cfg,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          joy_x,
	input  wire logic [7:0]          joy_y,
	input  wire logic [7:0]          status_byte,
	output logic                     push,
	output jtps_pkg::entry_t         push_entry,
	input  wire logic                q_full
);

	logic [jtps_pkg::NumKeys-1:0] key_flags_q;
	logic [jtps_pkg::NumKeys-1:0] now;
	logic [jtps_pkg::NumKeys-1:0] changed;
	logic [7:0]                   hi;
	logic [7:0]                   lo;
	logic                         accept;

	// Thresholds around the centre; both stay within 0..254.
	assign hi = jtps_pkg::Centre + {1'b0, cfg.dead_zone};
	assign lo = jtps_pkg::Centre - {1'b0, cfg.dead_zone};

	// Classify the report into the six key flags.
	always_comb begin
		now = '0;
		now[jtps_pkg::KeyUp] = joy_y > hi;
		now[jtps_pkg::KeyDown] = joy_y < lo;
		now[jtps_pkg::KeyLeft] = joy_x < lo;
		now[jtps_pkg::KeyRight] = joy_x > hi;
		now[jtps_pkg::KeyCtrl] = ~status_byte[1];
		now[jtps_pkg::KeySpace] = ~status_byte[0];
	end

	assign changed = now ^ key_flags_q;
	assign in_ready = ~q_full;
	assign accept = in_valid & in_ready;

	// Only reports that change something and are enabled reach the back end.
	assign push = accept & cfg.output_enable & (|changed);
	assign push_entry.changed = changed;
	assign push_entry.now = now;

	// Key state follows every accepted report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_flags_q <= '0;
		end else if (accept) begin
			key_flags_q <= now;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/jtps_queue.sv =====
// Short queue between the report front end and the byte generator.
// Two entries of jtps_pkg::entry_t. Depends on jtps_pkg.
`default_nettype none

module jtps_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire jtps_pkg::entry_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  q_valid,
	output jtps_pkg::entry_t      head
);

	jtps_pkg::entry_t mem_q [jtps_pkg::QueueDepth];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full = count_q == 2'(jtps_pkg::QueueDepth);
	assign q_valid = count_q != 2'd0;
	assign head = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/jtps_back.sv =====
// Back end: walks a report's changed keys and emits one byte a cycle while
// the output is not stalled. Holds the output register. Depends on jtps_pkg.
`default_nettype none

module jtps_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire jtps_pkg::entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            scan_byte,
	output logic                  last_byte
);

	logic [jtps_pkg::NumKeys-1:0] pending_q;
	logic [jtps_pkg::NumKeys-1:0] now_q;
	logic [1:0]                   phase_q;
	logic                         out_valid_q;
	logic [7:0]                   scan_byte_q;
	logic                         last_byte_q;

	logic [jtps_pkg::KeyIdxW-1:0] k;
	logic [1:0]                   eff_phase;
	logic [7:0]                   byte_w;
	logic [jtps_pkg::NumKeys-1:0] rest;
	logic                         last_w;
	logic                         emit;

	// Lowest pending key goes first.
	always_comb begin
		k = '0;
		for (int i = jtps_pkg::NumKeys - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				k = jtps_pkg::KeyIdxW'(i);
			end
		end
	end

	// Skip the prefix phases that this key does not need.
	always_comb begin
		eff_phase = phase_q;
		if (eff_phase == jtps_pkg::PhEsc && !jtps_pkg::key_escaped(k)) begin
			eff_phase = jtps_pkg::PhBreak;
		end
		if (eff_phase == jtps_pkg::PhBreak && now_q[k]) begin
			eff_phase = jtps_pkg::PhCode;
		end
		case (eff_phase)
			jtps_pkg::PhEsc: byte_w = jtps_pkg::PrefixEsc;
			jtps_pkg::PhBreak: byte_w = jtps_pkg::PrefixBreak;
			default: byte_w = jtps_pkg::key_code(k);
		endcase
		rest = pending_q;
		rest[k] = 1'b0;
	end

	assign last_w = (eff_phase == jtps_pkg::PhCode) && (rest == '0);
	assign emit = (pending_q != '0) && (!out_valid_q || out_ready);
	assign pop = q_valid && ((pending_q == '0) || (emit && last_w));

	// Sequencer over the keys of the current report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			phase_q <= jtps_pkg::PhEsc;
		end else if (pop) begin
			pending_q <= head.changed;
			phase_q <= jtps_pkg::PhEsc;
		end else if (emit) begin
			if (eff_phase == jtps_pkg::PhCode) begin
				pending_q <= rest;
				phase_q <= jtps_pkg::PhEsc;
			end else begin
				phase_q <= eff_phase + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			now_q <= head.now;
		end
	end

	// Output register; a new beat loads when the old one is taken or absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			scan_byte_q <= byte_w;
			last_byte_q <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign scan_byte = scan_byte_q;
	assign last_byte = last_byte_q;

endmodule

`default_nettype wire

// ===== hw/rtl/joystick_to_ps2_scancode.sv =====
// Joystick report to PS/2 set-2 scancode converter, top level.
// Reports enter on a valid/ready channel carrying joy_x, joy_y and status_byte.
// The axes and the two active-low buttons become six key flags; every change
// produces a make or break sequence (E0 for arrows, F0 for releases, then the
// key code) on the output channel, one byte per beat, last_byte on the final one.
// An APB port holds output_enable (address 0) and dead_zone (address 4).
// An accepted report goes into the queue, then into the sequencer, and its
// first byte into the output register. Bytes go out one per cycle unless the
// receiver stalls. A report gives up to 14 bytes; an unchanged one is not queued.
// A two-entry queue between classifier and generator lets reports be taken
// while bytes of earlier ones are still going out.
// When the receiver stalls, the output register holds its beat, the queue fills
// and in_ready falls once both entries are occupied.
// Reset releases all keys, disables output and sets the dead zone to 50.
// Depends on jtps_pkg, jtps_front, jtps_queue and jtps_back.
`default_nettype none

module joystick_to_ps2_scancode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  joy_x,
	input  wire logic [7:0]  joy_y,
	input  wire logic [7:0]  status_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       scan_byte,
	output logic             last_byte
);

	jtps_pkg::cfg_t   cfg_q;
	jtps_pkg::entry_t push_entry;
	jtps_pkg::entry_t head;
	logic             push;
	logic             q_full;
	logic             q_valid;
	logic             pop;
	logic             wr_en;

	// Configuration registers.
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_enable <= 1'b0;
			cfg_q.dead_zone <= jtps_pkg::DeadZoneReset;
		end else if (wr_en) begin
			case (paddr[2])
				jtps_pkg::RegOutputEnable: cfg_q.output_enable <= pwdata[0];
				jtps_pkg::RegDeadZone: cfg_q.dead_zone <= pwdata[6:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (paddr[2])
			jtps_pkg::RegOutputEnable: prdata = {31'd0, cfg_q.output_enable};
			jtps_pkg::RegDeadZone: prdata = {25'd0, cfg_q.dead_zone};
			default: prdata = '0;
		endcase
	end

	jtps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.joy_x       (joy_x),
		.joy_y       (joy_y),
		.status_byte (status_byte),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	jtps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	jtps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scan_byte (scan_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire

// ===== test/tb_joystick_to_ps2_scancode.sv =====
// Testbench for joystick_to_ps2_scancode: drives controller reports, predicts the
// PS/2 set-2 byte stream, and checks every output beat against the prediction.
// Depends on jtps_pkg and the joystick_to_ps2_scancode RTL.
`timescale 1ns / 100ps

module tb_joystick_to_ps2_scancode;

	// Key codes in flag order: up, down, left, right, ctrl, space.
	localparam logic [jtps_pkg::NumKeys-1:0][7:0] ScanCodes =
		{8'h29, 8'h14, 8'h74, 8'h6B, 8'h72, 8'h75};
	localparam int SettleCycles = 40;
	localparam int CycleLimit = 600000;
	localparam int MaxReported = 10;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] st;
	} report_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} scan_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  joy_x = '0;
	logic [7:0]  joy_y = '0;
	logic [7:0]  status_byte = 8'hFF;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  scan_byte;
	logic        last_byte;

	// Predictor state and its copy of the configuration registers.
	logic                         model_oe = 1'b0;
	logic [6:0]                   model_dz = jtps_pkg::DeadZoneReset;
	logic [jtps_pkg::NumKeys-1:0] model_keys = '0;

	report_t    reports_pending[$];
	scan_beat_t scan_expected[$];
	report_t    last_report = '{x: 8'd127, y: 8'd127, st: 8'hFF};
	int         reports_queued = 0;
	int         reports_accepted = 0;
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         idle_on = 1'b0;
	int         gap_left = 0;
	int         stall_left = 0;
	report_t    next_report;
	scan_beat_t beat_want;

	joystick_to_ps2_scancode dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.joy_x(joy_x),
		.joy_y(joy_y),
		.status_byte(status_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scan_byte(scan_byte),
		.last_byte(last_byte)
	);

	always #10 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MaxReported)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// Turns one report into its make/break bytes and updates the key flags.
	function automatic void predict_scancodes(input report_t rep);
		logic [7:0]                   hi;
		logic [7:0]                   lo;
		logic [jtps_pkg::NumKeys-1:0] pressed;
		int                           added;
		added = 0;
		hi = jtps_pkg::Centre + {1'b0, model_dz};
		lo = jtps_pkg::Centre - {1'b0, model_dz};
		pressed = '0;
		pressed[jtps_pkg::KeyUp] = rep.y > hi;
		pressed[jtps_pkg::KeyDown] = rep.y < lo;
		pressed[jtps_pkg::KeyLeft] = rep.x < lo;
		pressed[jtps_pkg::KeyRight] = rep.x > hi;
		pressed[jtps_pkg::KeyCtrl] = ~rep.st[1];
		pressed[jtps_pkg::KeySpace] = ~rep.st[0];
		if (model_oe) begin
			for (int k = 0; k < jtps_pkg::NumKeys; k++) begin
				if (pressed[k] != model_keys[k]) begin
					// Arrows are extended keys and carry the E0 prefix.
					if (k <= jtps_pkg::KeyRight) begin
						scan_expected.push_back('{code: jtps_pkg::PrefixEsc, last: 1'b0});
						added++;
					end
					if (!pressed[k]) begin
						scan_expected.push_back('{code: jtps_pkg::PrefixBreak, last: 1'b0});
						added++;
					end
					scan_expected.push_back('{code: ScanCodes[k], last: 1'b0});
					added++;
				end
			end
			if (added > 0)
				scan_expected[scan_expected.size() - 1].last = 1'b1;
		end
		model_keys = pressed;
	endfunction

	// Input driver: takes reports from the pending queue; idle_on adds random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_scancodes('{x: joy_x, y: joy_y, st: status_byte});
				reports_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (reports_pending.size() > 0) begin
					next_report = reports_pending.pop_front();
					in_valid <= 1'b1;
					joy_x <= next_report.x;
					joy_y <= next_report.y;
					status_byte <= next_report.st;
					gap_left = idle_on ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Output monitor: each accepted beat must match the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (scan_expected.size() == 0) begin
				note_mismatch($sformatf("unexpected beat: scan_byte %02h last_byte %0b",
					scan_byte, last_byte));
			end else begin
				beat_want = scan_expected.pop_front();
				if (scan_byte !== beat_want.code)
					note_mismatch($sformatf("scan_byte expected %02h actual %02h",
						beat_want.code, scan_byte));
				if (last_byte !== beat_want.last)
					note_mismatch($sformatf("last_byte expected %0b actual %0b on byte %02h",
						beat_want.last, last_byte, beat_want.code));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == jtps_pkg::RegOutputEnable)
			model_oe = value[0];
		else
			model_dz = value[6:0];
	endtask

	task automatic push_report(input logic [7:0] x, input logic [7:0] y, input logic [7:0] st);
		last_report = '{x: x, y: y, st: st};
		reports_pending.push_back(last_report);
		reports_queued++;
	endtask

	// Waits until every report is taken and every byte is out, then lets the block settle.
	task automatic drain();
		while (reports_accepted != reports_queued || scan_expected.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Axis values cluster on the press thresholds, the rails and the centre.
	function automatic logic [7:0] axis_pick(input logic [7:0] prev);
		int v;
		case ($urandom_range(0, 9))
			0: v = jtps_pkg::Centre + model_dz + 1;
			1: v = jtps_pkg::Centre + model_dz;
			2: v = jtps_pkg::Centre - model_dz;
			3: v = jtps_pkg::Centre - model_dz - 1;
			4: v = 0;
			5: v = 255;
			6: v = jtps_pkg::Centre;
			7: v = prev;
			default: v = $urandom_range(0, 255);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	task automatic queue_random(input int count);
		logic [7:0] st;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				// Same report again: no key changes.
				0: push_report(last_report.x, last_report.y, last_report.st);
				// Pure noise.
				1: push_report(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: begin
					st = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 1))
						st[1:0] = last_report.st[1:0];
					push_report(axis_pick(last_report.x), axis_pick(last_report.y), st);
				end
			endcase
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Output disabled after reset: flags follow the report, no bytes.
		push_report(8'd127, 8'd255, 8'hFE);
		drain();
		reg_write(jtps_pkg::RegOutputEnable, 32'd1);

		// Directed reports at the default dead zone of 50.
		push_report(8'd127, 8'd127, 8'hFF);
		push_report(8'd127, 8'd178, 8'hFF);
		push_report(8'd127, 8'd177, 8'hFF);
		push_report(8'd127, 8'd76, 8'hFF);
		push_report(8'd127, 8'd77, 8'hFF);
		push_report(8'd76, 8'd127, 8'hFF);
		push_report(8'd178, 8'd127, 8'hFF);
		push_report(8'd127, 8'd127, 8'hFD);
		push_report(8'd127, 8'd127, 8'hFE);
		push_report(8'd127, 8'd127, 8'hFE);
		push_report(8'd127, 8'd127, 8'h02);
		push_report(8'd0, 8'd0, 8'hFC);
		push_report(8'd255, 8'd255, 8'hFF);
		push_report(8'd0, 8'd0, 8'h00);
		push_report(8'd255, 8'd255, 8'hFF);
		push_report(8'd127, 8'd127, 8'hFF);
		drain();

		// Zero dead zone: anything off centre presses.
		reg_write(jtps_pkg::RegDeadZone, 32'd0);
		push_report(8'd128, 8'd126, 8'hFF);
		push_report(8'd126, 8'd128, 8'hFF);
		push_report(8'd127, 8'd127, 8'hFF);
		drain();

		// Widest dead zone: only 255 presses, left and down never do.
		reg_write(jtps_pkg::RegDeadZone, 32'd127);
		push_report(8'd255, 8'd0, 8'hFF);
		push_report(8'd254, 8'd255, 8'hFC);
		push_report(8'd0, 8'd254, 8'hFF);
		drain();

		// Random phases over several settings.
		idle_on = 1'b1;
		reg_write(jtps_pkg::RegDeadZone, $urandom_range(1, 126));
		queue_random(60);
		drain();

		idle_on = 1'b0;
		reg_write(jtps_pkg::RegDeadZone, 32'd0);
		queue_random(40);
		drain();

		idle_on = 1'b1;
		reg_write(jtps_pkg::RegDeadZone, 32'd127);
		queue_random(40);
		drain();

		// Keys move while output is off; re-enabling reports against the tracked flags.
		reg_write(jtps_pkg::RegOutputEnable, 32'd0);
		reg_write(jtps_pkg::RegDeadZone, $urandom_range(0, 127));
		queue_random(20);
		drain();
		reg_write(jtps_pkg::RegOutputEnable, 32'd1);
		queue_random(60);
		drain();

		reg_write(jtps_pkg::RegDeadZone, 32'd50);
		queue_random(60);
		drain();

		if (mismatch_count == 0 && scan_expected.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
